// ===== sv/b2s_pkg.sv =====
// ----------------------------------------------------------------------------
// BLAKE2s-256 package
// Shared types, constants and schedule tables for the hash engine.
// ----------------------------------------------------------------------------
package b2s_pkg;

  localparam logic [31:0] ParamWord = 32'h0101_0020;
  localparam logic [31:0] AllOnes   = 32'hFFFF_FFFF;
  localparam int unsigned NumRounds = 10;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_FIN,
    ST_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // take input word into buffer
    logic start;      // set up work vector
    logic step;       // one half round
    logic finish;     // fold work vector into chain
    logic clear_blk;  // empty block buffer
    logic reset_all;  // back to reset state
    logic last;       // final block flag at setup
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic blk_full;   // sixteen words held
    logic rounds_done;
    logic no_bytes;   // incoming word carries no bytes
  } dp_sts_t;

  function automatic word_t iv(input logic [2:0] i);
    case (i)
      3'd0: iv = 32'h6A09E667;
      3'd1: iv = 32'hBB67AE85;
      3'd2: iv = 32'h3C6EF372;
      3'd3: iv = 32'hA54FF53A;
      3'd4: iv = 32'h510E527F;
      3'd5: iv = 32'h9B05688C;
      3'd6: iv = 32'h1F83D9AB;
      default: iv = 32'h5BE0CD19;
    endcase
  endfunction

  // message schedule: sigma row r, entry j
  function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] j);
    logic [63:0] row;
    row = 64'h0;
    case (r)
      4'd0: row = 64'hFEDCBA9876543210;
      4'd1: row = 64'h357B20C16DF984AE;
      4'd2: row = 64'h491763EADF250C8B;
      4'd3: row = 64'h8F04A562EBCD1397;
      4'd4: row = 64'hD386CB1EFA427509;
      4'd5: row = 64'h91EF57D438B0A6C2;
      4'd6: row = 64'hB8293670A4DEF15C;
      4'd7: row = 64'hA2684F05931CE7BD;
      4'd8: row = 64'h5A417D2C803B9EF6;
      default: row = 64'h0DC3E9BF5167482A;
    endcase
    sigma = row[j*4 +: 4];
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== sv/b2s_ctrl.sv =====
// ----------------------------------------------------------------------------
// BLAKE2s controller
// Sequences word intake, compression rounds and digest output.
// ----------------------------------------------------------------------------
module b2s_ctrl
  import b2s_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_final_i,
  input  logic    out_ready_i,
  input  logic    out_last_i,
  input  dp_sts_t sts_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   fin_q, fin_d;
  logic   lst_q, lst_d;   // compression in progress is the final one
  logic   acc;

  assign acc = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    lst_d   = lst_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          fin_d = in_final_i;
          if (sts_i.blk_full && !sts_i.no_bytes) state_d = ST_COMP;
          else if (in_final_i) state_d = ST_FIN;
        end
      end
      ST_COMP: begin
        if (sts_i.rounds_done) begin
          if (lst_q) state_d = ST_OUT;
          else if (fin_q) state_d = ST_FIN;
          else state_d = ST_IDLE;
        end
      end
      ST_FIN: begin
        state_d = ST_COMP;
        lst_d   = 1'b1;
      end
      ST_OUT: begin
        if (out_ready_i && out_last_i) begin
          state_d = ST_IDLE;
          fin_d   = 1'b0;
          lst_d   = 1'b0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (acc) begin
          if (sts_i.blk_full && !sts_i.no_bytes) begin
            cmd_o.start = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_COMP: begin
        cmd_o.step = 1'b1;
        if (sts_i.rounds_done) cmd_o.finish = 1'b1;
        if (sts_i.rounds_done && !lst_q) cmd_o.clear_blk = 1'b1;
      end
      ST_FIN: begin
        cmd_o.start = 1'b1;
        cmd_o.last  = 1'b1;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i && out_last_i) cmd_o.reset_all = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fin_q   <= 1'b0;
      lst_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      lst_q   <= lst_d;
    end
  end

endmodule

// ===== sv/b2s_dpath.sv =====
// ----------------------------------------------------------------------------
// BLAKE2s datapath
// Chain value, block buffer, counter and a four-lane G unit run per half round.
// ----------------------------------------------------------------------------
module b2s_dpath
  import b2s_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [31:0] msg_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        final_word_i,
  input  logic        out_take_i,
  output dp_sts_t     sts_o,
  output logic [31:0] digest_word_o,
  output logic [2:0]  digest_index_o,
  output logic        digest_last_o
);

  word_t       h_q [8];
  word_t       m_q [16];
  word_t       v_q [16];
  logic [4:0]  nw_q;
  logic [31:0] cnt_q;
  logic [4:0]  hr_q;   // half round 0..19
  logic [2:0]  oi_q;
  // word held back while a full block compresses
  word_t       pw_q;
  logic [2:0]  pn_q;
  logic        pend_q;

  logic [2:0]  nb;
  word_t       wmask;
  word_t       vn [16];
  logic [3:0]  rnd;
  logic        diag;

  // clamp and mask of the incoming word
  always_comb begin
    nb = final_word_i ? ((valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i) : 3'd4;
    case (nb)
      3'd0: wmask = 32'h0;
      3'd1: wmask = 32'h0000_00FF;
      3'd2: wmask = 32'h0000_FFFF;
      3'd3: wmask = 32'h00FF_FFFF;
      default: wmask = AllOnes;
    endcase
  end

  assign rnd  = hr_q[4:1];
  assign diag = hr_q[0];

  // four G functions in parallel
  always_comb begin
    logic [3:0] a, b, c, d;
    word_t ta, tb, tc, td, x, y;
    for (int k = 0; k < 16; k++) vn[k] = v_q[k];
    for (int g = 0; g < 4; g++) begin
      a = 4'(g);
      b = diag ? 4'(4 + ((g + 1) % 4)) : 4'(4 + g);
      c = diag ? 4'(8 + ((g + 2) % 4)) : 4'(8 + g);
      d = diag ? 4'(12 + ((g + 3) % 4)) : 4'(12 + g);
      x = m_q[sigma(rnd, {diag, 2'(g), 1'b0})];
      y = m_q[sigma(rnd, {diag, 2'(g), 1'b1})];
      ta = v_q[a]; tb = v_q[b]; tc = v_q[c]; td = v_q[d];
      ta = ta + tb + x;
      td = ror(td ^ ta, 16);
      tc = tc + td;
      tb = ror(tb ^ tc, 12);
      ta = ta + tb + y;
      td = ror(td ^ ta, 8);
      tc = tc + td;
      tb = ror(tb ^ tc, 7);
      vn[a] = ta; vn[b] = tb; vn[c] = tc; vn[d] = td;
    end
  end

  assign sts_o.blk_full    = nw_q[4];
  assign sts_o.rounds_done = (hr_q == 5'd19);
  assign sts_o.no_bytes    = (nb == 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= iv(3'(i)) ^ ((i == 0) ? ParamWord : 32'h0);
      for (int i = 0; i < 16; i++) m_q[i] <= '0;
      for (int i = 0; i < 16; i++) v_q[i] <= '0;
      nw_q   <= '0;
      cnt_q  <= '0;
      hr_q   <= '0;
      oi_q   <= '0;
      pw_q   <= '0;
      pn_q   <= '0;
      pend_q <= 1'b0;
    end else begin
      if (cmd_i.load && nb != 3'd0) begin
        m_q[nw_q[3:0]] <= msg_word_i & wmask;
        nw_q  <= nw_q + 5'd1;
        cnt_q <= cnt_q + 32'(nb);
      end
      // full block: hold the word, compress first
      if (cmd_i.start && !cmd_i.last) begin
        pend_q <= (nb != 3'd0);
        pw_q   <= msg_word_i & wmask;
        pn_q   <= nb;
      end
      if (cmd_i.start) begin
        for (int i = 0; i < 8; i++) begin
          v_q[i]   <= h_q[i];
          v_q[i+8] <= iv(3'(i));
        end
        v_q[12] <= iv(3'd4) ^ cnt_q;
        v_q[14] <= cmd_i.last ? (iv(3'd6) ^ AllOnes) : iv(3'd6);
        hr_q    <= '0;
      end
      if (cmd_i.step) begin
        for (int k = 0; k < 16; k++) v_q[k] <= vn[k];
        hr_q <= hr_q + 5'd1;
      end
      if (cmd_i.finish) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ vn[i] ^ vn[i+8];
      end
      if (cmd_i.clear_blk) begin
        for (int i = 0; i < 16; i++) m_q[i] <= '0;
        nw_q <= '0;
        if (pend_q) begin
          m_q[0] <= pw_q;
          nw_q   <= 5'd1;
          cnt_q  <= cnt_q + 32'(pn_q);
        end
        pend_q <= 1'b0;
      end
      if (out_take_i) oi_q <= oi_q + 3'd1;
      if (cmd_i.reset_all) begin
        for (int i = 0; i < 8; i++) h_q[i] <= iv(3'(i)) ^ ((i == 0) ? ParamWord : 32'h0);
        for (int i = 0; i < 16; i++) m_q[i] <= '0;
        nw_q  <= '0;
        cnt_q <= '0;
        oi_q  <= '0;
      end
    end
  end

  assign digest_word_o  = h_q[oi_q];
  assign digest_index_o = oi_q;
  assign digest_last_o  = (oi_q == 3'd7);

endmodule

// ===== sv/blake2s_256_hash_top.sv =====
// ----------------------------------------------------------------------------
// BLAKE2s-256 hash top
// Unkeyed BLAKE2s, 32-bit message words in, eight digest words out.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                        | tuser | tlast
//  s_axis  | in  | msg_word[31:0],valid_bytes   | -     | final_word
//  m_axis  | out | digest_word[31:0],index[2:0] | -     | digest_last
//
//  A word into a partial block is taken straight into the buffer. A word
//  arriving on a full block compresses that block first: input stalls while
//  the G unit runs one half round per cycle. A final word then adds a setup
//  state and a compression, after which eight digest words drain at one per
//  cycle while m_axis_tready is high. Input is stalled during compression and
//  digest output. Reset is async, active low.
module blake2s_256_hash_top
  import b2s_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // msg_word[31:0], valid_bytes[34:32]
  input  logic        s_axis_tlast,   // final_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // digest_word[31:0], digest_index[34:32]
  output logic        m_axis_tlast    // digest_last
);

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [31:0] dw;
  logic [2:0]  di;
  logic        dl;

  b2s_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_final_i  (s_axis_tlast),
    .out_ready_i (m_axis_tready),
    .out_last_i  (dl),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  b2s_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .msg_word_i     (s_axis_tdata[31:0]),
    .valid_bytes_i  (s_axis_tdata[34:32]),
    .final_word_i   (s_axis_tlast),
    .out_take_i     (m_axis_tvalid && m_axis_tready),
    .sts_o          (sts),
    .digest_word_o  (dw),
    .digest_index_o (di),
    .digest_last_o  (dl)
  );

  assign m_axis_tdata = {5'b0, di, dw};
  assign m_axis_tlast = dl;

endmodule

// ===== sv/b2s_checker.sv =====
// ----------------------------------------------------------------------------
// BLAKE2s port checker
// Port-level properties of the hash top, bound to every instance.
// ----------------------------------------------------------------------------
module b2s_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // no input while digest words are pending
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready during output");

  // tlast matches index seven
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
    else $error("tlast mismatch");

  // index advances by one per word taken
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
    else $error("index skip");

  // after the last word the block is ready again
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("not idle after digest");

endmodule

bind blake2s_256_hash_top b2s_checker u_chk (.*);

// ===== tb/blake2s_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BLAKE2s-256 digest checker
// Watches both stream channels, hashes accepted message words with its own
// copy of the engine state and compares each digest word in order.
// ----------------------------------------------------------------------------
module blake2s_checker
  import b2s_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          digests_o
);

  typedef struct packed {
    logic [31:0] dword;
    logic [2:0]  idx;
    logic        lst;
  } digest_t;

  localparam logic [31:0] IvTab [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

  localparam logic [63:0] PermTab [10] = '{
    64'hFEDCBA9876543210, 64'h357B20C16DF984AE, 64'h491763EADF250C8B,
    64'h8F04A562EBCD1397, 64'hD386CB1EFA427509, 64'h91EF57D438B0A6C2,
    64'hB8293670A4DEF15C, 64'hA2684F05931CE7BD, 64'h5A417D2C803B9EF6,
    64'h0DC3E9BF5167482A};

  logic [31:0] chain [8];
  logic [31:0] blk [16];
  int unsigned nwords;
  logic [31:0] nbytes;
  // expected digest words, in order
  digest_t     exp_mem [16];
  int          wr_ptr;
  int          rd_ptr;
  int          fails;
  int          ndig;

  assign fail_cnt_o = fails;
  assign pending_o  = wr_ptr - rd_ptr;
  assign digests_o  = ndig;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic g_mix(inout logic [31:0] v[16], input int a, b, c, d,
                       input logic [31:0] x, y);
    v[a] = v[a] + v[b] + x;
    v[d] = rotr(v[d] ^ v[a], 16);
    v[c] = v[c] + v[d];
    v[b] = rotr(v[b] ^ v[c], 12);
    v[a] = v[a] + v[b] + y;
    v[d] = rotr(v[d] ^ v[a], 8);
    v[c] = v[c] + v[d];
    v[b] = rotr(v[b] ^ v[c], 7);
  endtask

  task automatic compress(input bit last);
    logic [31:0] v[16];
    logic [31:0] m[16];
    logic [63:0] s;
    for (int i = 0; i < 8; i++) begin
      v[i] = chain[i];
      v[i+8] = IvTab[i];
    end
    for (int i = 0; i < 16; i++) m[i] = blk[i];
    v[12] ^= nbytes;
    if (last) v[14] ^= AllOnes;
    for (int r = 0; r < NumRounds; r++) begin
      s = PermTab[r];
      g_mix(v, 0, 4, 8, 12, m[s[3:0]], m[s[7:4]]);
      g_mix(v, 1, 5, 9, 13, m[s[11:8]], m[s[15:12]]);
      g_mix(v, 2, 6, 10, 14, m[s[19:16]], m[s[23:20]]);
      g_mix(v, 3, 7, 11, 15, m[s[27:24]], m[s[31:28]]);
      g_mix(v, 0, 5, 10, 15, m[s[35:32]], m[s[39:36]]);
      g_mix(v, 1, 6, 11, 12, m[s[43:40]], m[s[47:44]]);
      g_mix(v, 2, 7, 8, 13, m[s[51:48]], m[s[55:52]]);
      g_mix(v, 3, 4, 9, 14, m[s[59:56]], m[s[63:60]]);
    end
    for (int i = 0; i < 8; i++) chain[i] ^= v[i] ^ v[i+8];
  endtask

  task automatic hash_init();
    for (int i = 0; i < 8; i++) chain[i] = IvTab[i];
    chain[0] ^= ParamWord;
    for (int i = 0; i < 16; i++) blk[i] = '0;
    nwords = 0;
    nbytes = '0;
  endtask

  task automatic append(logic [31:0] w, logic [31:0] n);
    if (nwords >= 16) begin
      compress(1'b0);
      for (int i = 0; i < 16; i++) blk[i] = '0;
      nwords = 0;
    end
    blk[nwords] = w;
    nwords++;
    nbytes += n;
  endtask

  task automatic absorb_word(logic [31:0] w, logic [2:0] vb, logic fin);
    logic [2:0] n;
    logic [31:0] mask;
    digest_t d;
    if (!fin) begin
      append(w, 32'd4);
      return;
    end
    n = (vb > 3'd4) ? 3'd4 : vb;
    if (n != 0) begin
      mask = (n == 3'd4) ? AllOnes : ((32'd1 << (8 * n)) - 32'd1);
      append(w & mask, {29'd0, n});
    end
    compress(1'b1);
    for (int k = 0; k < 8; k++) begin
      d.dword = chain[k];
      d.idx   = 3'(k);
      d.lst   = (k == 7);
      exp_mem[wr_ptr % 16] = d;
      wr_ptr++;
    end
    hash_init();
  endtask

  initial begin
    fails = 0;
    ndig = 0;
    wr_ptr = 0;
    rd_ptr = 0;
    hash_init();
  end

  // sample both channels at the edge
  always @(posedge clk_i) begin
    digest_t e;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (wr_ptr == rd_ptr) begin
          $display("%0t: unexpected digest word, actual %h last %b", $time,
                   m_axis_tdata[34:0], m_axis_tlast);
          fails++;
        end else begin
          e = exp_mem[rd_ptr % 16];
          rd_ptr++;
          ndig++;
          if (m_axis_tdata[31:0] !== e.dword || m_axis_tdata[34:32] !== e.idx ||
              m_axis_tlast !== e.lst || m_axis_tdata[39:35] !== 5'd0) begin
            $display("%0t: digest word mismatch, expected %h idx %0d last %b, %s",
                     $time, e.dword, e.idx, e.lst, "actual:");
            $display("    actual %h idx %0d last %b", m_axis_tdata[31:0],
                     m_axis_tdata[34:32], m_axis_tlast);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        absorb_word(s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tlast);
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BLAKE2s-256 hash testbench
// Drives messages of many lengths with random gaps and back pressure; the
// checker predicts every digest word and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // msg_word[31:0], valid_bytes[34:32]
  logic        s_axis_tlast = 1'b0; // final_word
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // digest_word[31:0], digest_index[34:32]
  logic        m_axis_tlast;        // digest_last

  int fail_cnt, pending, ndig;
  int words_sent = 0;
  int msgs_sent = 0;
  bit rx_run = 1'b0;

  blake2s_256_hash_top u_top (.*);

  blake2s_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .m_axis_tlast, .fail_cnt_o(fail_cnt), .pending_o(pending), .digests_o(ndig));

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls at random
  always @(posedge clk_i) begin
    if (rx_run) begin
      if ($urandom_range(0, 9) < 2) m_axis_tready <= 1'b0;
      else if ($urandom_range(0, 29) == 0) m_axis_tready <= 1'b0;
      else m_axis_tready <= 1'b1;
    end
  end

  // one word, held until accepted; valid drops only ahead of a gap
  task automatic send_word(logic [31:0] w, logic [2:0] vb, logic fin);
    int g;
    g = gap_len();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, vb, w};
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // stop sending and wait for every expected digest word
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_msg(int nfull, logic [2:0] vb_last, bit rnd_bytes);
    logic [2:0] vb;
    for (int i = 0; i < nfull; i++) begin
      // non-final words may carry any count; it must be ignored
      vb = rnd_bytes ? 3'($urandom_range(0, 7)) : 3'd4;
      send_word($urandom(), vb, 1'b0);
    end
    send_word($urandom(), vb_last, 1'b1);
    msgs_sent++;
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    rx_run = 1'b1;
    @(posedge clk_i);

    // directed: empty message, short words, block boundaries
    send_word(32'h0000_0000, 3'd0, 1'b1); msgs_sent++;
    send_word(32'hFFFF_FFFF, 3'd1, 1'b1); msgs_sent++;
    send_word(32'hFFFF_FFFF, 3'd3, 1'b1); msgs_sent++;
    send_word(32'hFFFF_FFFF, 3'd7, 1'b1); msgs_sent++;
    send_msg(15, 3'd4, 1'b0);  // exactly one full block
    send_msg(16, 3'd0, 1'b1);  // full block finalized by empty word
    send_msg(16, 3'd2, 1'b0);  // full block, then a partial final word

    // hold off until the digests are out
    drain();

    // random messages, mostly short, a few spanning several blocks
    while (words_sent < 95) begin
      if ($urandom_range(0, 9) < 2) n = $urandom_range(15, 34);
      else n = $urandom_range(0, 6);
      send_msg(n, 3'($urandom_range(0, 7)), $urandom_range(0, 1));
    end

    drain();
    repeat (50) @(posedge clk_i);
    $display("sent %0d words in %0d messages, checked %0d digest words",
             words_sent, msgs_sent, ndig);
    if (fail_cnt == 0) $display("blake2s_256_hash_top: match");
    else $display("blake2s_256_hash_top: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("blake2s_256_hash_top: mismatch");
    $finish;
  end

endmodule

// ===== blake2s_256_hash_top.f =====
sv/b2s_pkg.sv
sv/b2s_ctrl.sv
sv/b2s_dpath.sv
sv/blake2s_256_hash_top.sv
sv/b2s_checker.sv
tb/blake2s_checker.sv
tb/testbench.sv
